// ----- src/tpot_pkg.sv -----
`timescale 1ns / 1ps
// Package for the triangle pair overlap test.
// Holds the coordinate width, the vertex and axis counts and the derived data types.
// Depends on nothing.
package tpot_pkg;

   localparam int COORD_BITS  = 16;
   localparam int VERT_COUNT  = 3;
   localparam int POINT_COUNT = 2 * VERT_COUNT;
   localparam int AXIS_COUNT  = 2 * VERT_COUNT;
   localparam int DELTA_BITS  = COORD_BITS + 1;
   localparam int PROD_BITS   = COORD_BITS + DELTA_BITS;
   localparam int PROJ_BITS   = PROD_BITS + 1;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [DELTA_BITS-1:0] delta_type;
   typedef logic signed [PROD_BITS-1:0]  prod_type;
   typedef logic signed [PROJ_BITS-1:0]  proj_type;

endpackage

// ----- src/triangle_pair_overlap_test_top.sv -----
`timescale 1ns / 1ps
// Triangle pair overlap test by separating edge axes, as a seven-stage pipeline.
// Depends on tpot_pkg for widths and types.
//
//   channel   handshake           payload
//   request   start, busy         req_first_*, req_second_* vertex coordinates
//   result    rsp_strobe          rsp_overlap
//
// One item can enter in every cycle while busy is low; each result leaves the result register with rsp_strobe.
// The stages are: input register, edge normals, products, projections, interval
// ends, per-axis separation, result register.
// Busy is high only while reset is high; reset clears all valid bits.
// The receiver cannot stall, so the pipeline never holds.
module triangle_pair_overlap_test_top
   import tpot_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [COORD_BITS-1:0] req_first_x0,
   input  logic [COORD_BITS-1:0] req_first_y0,
   input  logic [COORD_BITS-1:0] req_first_x1,
   input  logic [COORD_BITS-1:0] req_first_y1,
   input  logic [COORD_BITS-1:0] req_first_x2,
   input  logic [COORD_BITS-1:0] req_first_y2,
   input  logic [COORD_BITS-1:0] req_second_x0,
   input  logic [COORD_BITS-1:0] req_second_y0,
   input  logic [COORD_BITS-1:0] req_second_x1,
   input  logic [COORD_BITS-1:0] req_second_y1,
   input  logic [COORD_BITS-1:0] req_second_x2,
   input  logic [COORD_BITS-1:0] req_second_y2,
   output logic                  rsp_strobe,
   output logic                  rsp_overlap
);

   localparam int LATENCY = 7;

   function automatic proj_type min3(input proj_type a, input proj_type b, input proj_type c);
      proj_type m;
      m = (a < b) ? a : b;
      return (c < m) ? c : m;
   endfunction

   function automatic proj_type max3(input proj_type a, input proj_type b, input proj_type c);
      proj_type m;
      m = (a > b) ? a : b;
      return (c > m) ? c : m;
   endfunction

   logic req_accept;

   logic      v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff, v7_ff;
   coord_type vx_in  [POINT_COUNT];
   coord_type vy_in  [POINT_COUNT];
   coord_type vx_ff  [POINT_COUNT];
   coord_type vy_ff  [POINT_COUNT];
   coord_type vx2_ff [POINT_COUNT];
   coord_type vy2_ff [POINT_COUNT];
   delta_type nx_in  [AXIS_COUNT];
   delta_type ny_in  [AXIS_COUNT];
   delta_type nx_ff  [AXIS_COUNT];
   delta_type ny_ff  [AXIS_COUNT];
   prod_type  mx_in  [AXIS_COUNT][POINT_COUNT];
   prod_type  my_in  [AXIS_COUNT][POINT_COUNT];
   prod_type  mx_ff  [AXIS_COUNT][POINT_COUNT];
   prod_type  my_ff  [AXIS_COUNT][POINT_COUNT];
   proj_type  proj_in [AXIS_COUNT][POINT_COUNT];
   proj_type  proj_ff [AXIS_COUNT][POINT_COUNT];
   proj_type  lo_in  [AXIS_COUNT][2];
   proj_type  hi_in  [AXIS_COUNT][2];
   proj_type  lo_ff  [AXIS_COUNT][2];
   proj_type  hi_ff  [AXIS_COUNT][2];
   logic [AXIS_COUNT-1:0] sep_in;
   logic [AXIS_COUNT-1:0] sep_ff;
   logic      overlap_in;
   logic      overlap_ff;

   assign busy       = reset;
   assign req_accept = start && !busy;

   assign vx_in[0] = req_first_x0;
   assign vy_in[0] = req_first_y0;
   assign vx_in[1] = req_first_x1;
   assign vy_in[1] = req_first_y1;
   assign vx_in[2] = req_first_x2;
   assign vy_in[2] = req_first_y2;
   assign vx_in[3] = req_second_x0;
   assign vy_in[3] = req_second_y0;
   assign vx_in[4] = req_second_x1;
   assign vy_in[4] = req_second_y1;
   assign vx_in[5] = req_second_x2;
   assign vy_in[5] = req_second_y2;

   // Edge normal of edge tail -> head is (-dy, dx).
   for (genvar a = 0; a < AXIS_COUNT; a++) begin : g_axis
      localparam int Base = (a / VERT_COUNT) * VERT_COUNT;
      localparam int Tail = Base + (a % VERT_COUNT);
      localparam int Head = Base + ((a % VERT_COUNT) + 1) % VERT_COUNT;
      assign nx_in[a] = DELTA_BITS'(vy_ff[Tail]) - DELTA_BITS'(vy_ff[Head]);
      assign ny_in[a] = DELTA_BITS'(vx_ff[Head]) - DELTA_BITS'(vx_ff[Tail]);
   end

   always_comb begin
      for (int a = 0; a < AXIS_COUNT; a++) begin
         for (int p = 0; p < POINT_COUNT; p++) begin
            mx_in[a][p]   = PROD_BITS'(vx2_ff[p]) * PROD_BITS'(nx_ff[a]);
            my_in[a][p]   = PROD_BITS'(vy2_ff[p]) * PROD_BITS'(ny_ff[a]);
            proj_in[a][p] = PROJ_BITS'(mx_ff[a][p]) + PROJ_BITS'(my_ff[a][p]);
         end
         for (int t = 0; t < 2; t++) begin
            lo_in[a][t] = min3(proj_ff[a][t*VERT_COUNT], proj_ff[a][t*VERT_COUNT+1],
                               proj_ff[a][t*VERT_COUNT+2]);
            hi_in[a][t] = max3(proj_ff[a][t*VERT_COUNT], proj_ff[a][t*VERT_COUNT+1],
                               proj_ff[a][t*VERT_COUNT+2]);
         end
         sep_in[a] = (hi_ff[a][0] < lo_ff[a][1]) || (hi_ff[a][1] < lo_ff[a][0]);
      end
      overlap_in = ~|sep_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
      end else begin
         v1_ff <= req_accept;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
         v7_ff <= v6_ff;
      end
   end

   always_ff @(posedge clock) begin
      vx_ff      <= vx_in;
      vy_ff      <= vy_in;
      vx2_ff     <= vx_ff;
      vy2_ff     <= vy_ff;
      nx_ff      <= nx_in;
      ny_ff      <= ny_in;
      mx_ff      <= mx_in;
      my_ff      <= my_in;
      proj_ff    <= proj_in;
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      sep_ff     <= sep_in;
      overlap_ff <= overlap_in;
   end

   assign rsp_strobe  = v7_ff;
   assign rsp_overlap = overlap_ff;

   logic same_pair;
   assign same_pair = req_accept &&
                      (req_first_x0 == req_second_x0) && (req_first_y0 == req_second_y0) &&
                      (req_first_x1 == req_second_x1) && (req_first_y1 == req_second_y1) &&
                      (req_first_x2 == req_second_x2) && (req_first_y2 == req_second_y2);

   a_strobe_has_item: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(req_accept, LATENCY))
      else $error("Result strobe without an item taken at the pipeline latency.");

   a_item_gives_result: assert property (@(posedge clock) disable iff (reset)
      req_accept |-> ##LATENCY rsp_strobe)
      else $error("An item taken did not produce a result at the pipeline latency.");

   a_same_pair_overlaps: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && $past(same_pair, LATENCY)) |-> rsp_overlap)
      else $error("Two identical triangles were reported as separated.");

endmodule
